// File: hw/rtl/qrgm_pkg.sv
// Shared types and constants for the quadrilateral grid mask block.
// Holds the fixed field widths, the scaling constants and the edge setup record.
// No dependencies.
package qrgm_pkg;

    // Grid and source geometry
    localparam int GRID_COLS     = 160;
    localparam int GRID_ROWS     = 90;
    localparam int SOURCE_WIDTH  = 704;
    localparam int SOURCE_HEIGHT = 576;

    // Field widths
    localparam int CORNER_W  = 10;
    localparam int ROW_W     = 7;
    localparam int COL_W     = 8;
    localparam int REG_IDX_W = 3;
    localparam int NUM_EDGES = 4;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 16;

    // Scale factors of the exact integer form
    localparam int VX_SCALE = 2 * GRID_COLS;
    localparam int VY_SCALE = 2 * GRID_ROWS;

    // Largest scaled coordinate over corners and cell centers
    localparam int VX_MAX  = (2 ** CORNER_W - 1) * VX_SCALE;
    localparam int VY_MAX  = (2 ** CORNER_W - 1) * VY_SCALE;
    localparam int CX_MAX  = SOURCE_WIDTH * (2 * (2 ** COL_W - 1) + 1);
    localparam int CY_MAX  = SOURCE_HEIGHT * (2 * (2 ** ROW_W - 1) + 1);
    localparam int X_MAX   = (VX_MAX > CX_MAX) ? VX_MAX : CX_MAX;
    localparam int Y_MAX   = (VY_MAX > CY_MAX) ? VY_MAX : CY_MAX;
    localparam int POS_MAX = (X_MAX > Y_MAX) ? X_MAX : Y_MAX;

    localparam int POS_W = $clog2(POS_MAX + 1);
    localparam int DIF_W = POS_W + 1;
    localparam int PRD_W = 2 * DIF_W;

    typedef logic [POS_W-1:0]        pos_t;
    typedef logic signed [DIF_W-1:0] dif_t;
    typedef logic signed [PRD_W-1:0] prd_t;

    // Configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_A_X = 3'd0,
        REG_A_Y = 3'd1,
        REG_B_X = 3'd2,
        REG_B_Y = 3'd3,
        REG_C_X = 3'd4,
        REG_C_Y = 3'd5,
        REG_D_X = 3'd6,
        REG_D_Y = 3'd7
    } cfg_reg_e;

    // Per-edge setup derived from the corners: start point i, end point j
    typedef struct packed {
        pos_t xi;
        pos_t yi;
        pos_t yj;
        dif_t dx;   // xj - xi
        dif_t dy;   // yj - yi
        logic up;   // yj > yi
    } edge_cfg_t;

endpackage

// File: hw/rtl/qrgm_cfg.sv
// Corner registers and the per-edge setup derived from them.
// Depends on qrgm_pkg.
module qrgm_cfg (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [qrgm_pkg::REG_IDX_W-1:0]         cfg_index,
    input  logic [qrgm_pkg::CORNER_W-1:0]          cfg_data,
    output qrgm_pkg::edge_cfg_t [qrgm_pkg::NUM_EDGES-1:0] edge_cfg
);
    import qrgm_pkg::*;

    logic [CORNER_W-1:0] corner_x_reg [NUM_EDGES];
    logic [CORNER_W-1:0] corner_y_reg [NUM_EDGES];
    pos_t                vx [NUM_EDGES];
    pos_t                vy [NUM_EDGES];
    edge_cfg_t [NUM_EDGES-1:0] edge_next;
    edge_cfg_t [NUM_EDGES-1:0] edge_reg;

    assign cfg_ready = 1'b1;

    // Store a corner coordinate on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_EDGES; k++) begin
                corner_x_reg[k] <= '0;
                corner_y_reg[k] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_e'(cfg_index))
                REG_A_X: corner_x_reg[0] <= cfg_data;
                REG_A_Y: corner_y_reg[0] <= cfg_data;
                REG_B_X: corner_x_reg[1] <= cfg_data;
                REG_B_Y: corner_y_reg[1] <= cfg_data;
                REG_C_X: corner_x_reg[2] <= cfg_data;
                REG_C_Y: corner_y_reg[2] <= cfg_data;
                REG_D_X: corner_x_reg[3] <= cfg_data;
                REG_D_Y: corner_y_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Scale corners into the common integer frame
    always_comb begin
        for (int k = 0; k < NUM_EDGES; k++) begin
            vx[k] = POS_W'(corner_x_reg[k]) * POS_W'(VX_SCALE);
            vy[k] = POS_W'(corner_y_reg[k]) * POS_W'(VY_SCALE);
        end
    end

    // Edge k runs from corner k to the previous corner (a-d, b-a, c-b, d-c)
    always_comb begin
        for (int k = 0; k < NUM_EDGES; k++) begin
            edge_next[k].xi = vx[k];
            edge_next[k].yi = vy[k];
            edge_next[k].yj = vy[(k + NUM_EDGES - 1) % NUM_EDGES];
            edge_next[k].dx = $signed({1'b0, vx[(k + NUM_EDGES - 1) % NUM_EDGES]})
                              - $signed({1'b0, vx[k]});
            edge_next[k].dy = $signed({1'b0, vy[(k + NUM_EDGES - 1) % NUM_EDGES]})
                              - $signed({1'b0, vy[k]});
            edge_next[k].up = vy[(k + NUM_EDGES - 1) % NUM_EDGES] > vy[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_reg <= '0;
        end else begin
            edge_reg <= edge_next;
        end
    end

    assign edge_cfg = edge_reg;

endmodule

// File: hw/rtl/qrgm_edge.sv
// One edge of the crossing test: offsets, cross products and the strict compare.
// Depends on qrgm_pkg; stage enables come from the top-level pipeline control.
module qrgm_edge (
    input  logic                aclk,
    input  logic                en2,
    input  logic                en3,
    input  qrgm_pkg::pos_t      cx,
    input  qrgm_pkg::pos_t      cy,
    input  qrgm_pkg::edge_cfg_t ecfg,
    output logic                hit
);
    import qrgm_pkg::*;

    dif_t a_reg;
    dif_t b_reg;
    logic cross2_reg;
    logic up2_reg;
    prd_t lhs_reg;
    prd_t rhs_reg;
    logic cross3_reg;
    logic up3_reg;

    // Stage 2: offsets from the edge start and the half-open straddle test on y
    always_ff @(posedge aclk) begin
        if (en2) begin
            a_reg      <= $signed({1'b0, cx}) - $signed({1'b0, ecfg.xi});
            b_reg      <= $signed({1'b0, cy}) - $signed({1'b0, ecfg.yi});
            cross2_reg <= (cy < ecfg.yi) ^ (cy < ecfg.yj);
            up2_reg    <= ecfg.up;
        end
    end

    // Stage 3: cross-multiply instead of dividing by the y span
    always_ff @(posedge aclk) begin
        if (en3) begin
            lhs_reg    <= PRD_W'(a_reg) * PRD_W'(ecfg.dy);
            rhs_reg    <= PRD_W'(ecfg.dx) * PRD_W'(b_reg);
            cross3_reg <= cross2_reg;
            up3_reg    <= up2_reg;
        end
    end

    // Compare direction follows the sign of the y span
    assign hit = cross3_reg && (up3_reg ? (lhs_reg < rhs_reg) : (lhs_reg > rhs_reg));

endmodule

// File: hw/rtl/quad_region_grid_mask.sv
// Top level of the quadrilateral grid mask: stream ports, pipeline control,
// cell center scaling and crossing-number parity. Uses qrgm_pkg, qrgm_cfg, qrgm_edge.
//
// Usage:
//   Write the four corners (source pixels) through the cfg_* channel while no
//   cell is in flight; index 0..7 selects a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y.
//   Feed cells (row, column) on s_*; each yields one transfer on m_* carrying
//   the inside flag and the echoed row and column, in input order.
// Timing:
//   Four register stages: center scale, edge offsets, cross products, then the
//   output register holding the compare parity. One cell per cycle is sustained
//   while m_tready stays high, set by the four parallel edge multiplier pairs in
//   stage 3.
// Reset:
//   aresetn (synchronous, active low) clears corners to zero and empties the
//   pipeline. cfg_ready is always high.
// Stall:
//   When m_tready is low, stages fill up behind the output register; s_tready
//   drops only once every stage holds a cell. No cell is lost or repeated.
module quad_region_grid_mask (
    input  logic                               aclk,
    input  logic                               aresetn,
    // tdata: cell_row [6:0], cell_col [14:7], zero [15]
    input  logic [qrgm_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata: inside_res [0], out_row [7:1], out_col [15:8]
    output logic [qrgm_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [qrgm_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [qrgm_pkg::CORNER_W-1:0]      cfg_data
);
    import qrgm_pkg::*;

    edge_cfg_t [NUM_EDGES-1:0] edge_cfg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic [ROW_W-1:0] row1_reg, row2_reg, row3_reg, row4_reg;
    logic [COL_W-1:0] col1_reg, col2_reg, col3_reg, col4_reg;
    pos_t             cx1_reg;
    pos_t             cy1_reg;
    logic [ROW_W-1:0] s_row;
    logic [COL_W-1:0] s_col;
    logic [NUM_EDGES-1:0] hit;
    logic             inside_reg;

    qrgm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .edge_cfg  (edge_cfg)
    );

    // Stage enables: a stage loads when empty or when the next one loads
    assign en4 = !v4_reg || m_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    assign s_row = s_tdata[ROW_W-1:0];
    assign s_col = s_tdata[ROW_W+COL_W-1:ROW_W];

    // Stage 1: scale the cell center into the common integer frame
    always_ff @(posedge aclk) begin
        if (en1) begin
            row1_reg <= s_row;
            col1_reg <= s_col;
            cx1_reg  <= POS_W'(SOURCE_WIDTH) * POS_W'({s_col, 1'b1});
            cy1_reg  <= POS_W'(SOURCE_HEIGHT) * POS_W'({s_row, 1'b1});
        end
    end

    // Stages 2 and 3 per edge
    for (genvar k = 0; k < NUM_EDGES; k++) begin : g_edge
        qrgm_edge u_edge (
            .aclk (aclk),
            .en2  (en2),
            .en3  (en3),
            .cx   (cx1_reg),
            .cy   (cy1_reg),
            .ecfg (edge_cfg[k]),
            .hit  (hit[k])
        );
    end

    // Carry the cell indexes alongside
    always_ff @(posedge aclk) begin
        if (en2) begin
            row2_reg <= row1_reg;
            col2_reg <= col1_reg;
        end
        if (en3) begin
            row3_reg <= row2_reg;
            col3_reg <= col2_reg;
        end
        if (en4) begin
            row4_reg   <= row3_reg;
            col4_reg   <= col3_reg;
            inside_reg <= ^hit;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {col4_reg, row4_reg, inside_reg};

    // Checks on the pipeline control
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted cell did not enter stage 1");

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> v1_reg && v2_reg && v3_reg && v4_reg)
        else $error("input blocked with a bubble in the pipeline");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && en3 |=> v3_reg)
        else $error("stage 2 cell lost on advance");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !v1_reg)
        else $error("pipeline not empty after reset");

endmodule

// File: verif/quad_region_grid_mask_tb.sv
// Self-checking testbench for quad_region_grid_mask: streams grid cells through the
// block and compares every mask transfer against an exact integer crossing-number
// predictor or a typed-in mask bit. Depends on qrgm_pkg and quad_region_grid_mask RTL only.
module quad_region_grid_mask_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qrgm_pkg::*;

    localparam int RANDOM_CELLS = 1100;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 90;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 16;
    localparam int N_PROBES     = 25;
    localparam int MAX_ROW      = 2 ** ROW_W - 1;
    localparam int MAX_COL      = 2 ** COL_W - 1;
    localparam int MAX_CORNER   = 2 ** CORNER_W - 1;

    typedef logic [CORNER_W-1:0] quad_regs_t [8];

    typedef struct packed {
        logic             in_quad;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } mask_rec_t;

    // Directed cell: corner set index, cell, and a typed-in mask bit where obvious
    typedef struct {
        int ph;
        int row;
        int col;
        bit known;
        bit want;
    } probe_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_style_e;
    typedef enum int {QD_SOURCE, QD_FULL, QD_EXTREME, QD_GRID_RECT} quad_style_e;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [CORNER_W-1:0]   cfg_data  = '0;

    quad_regs_t  quad_now = '{default: '0};
    mask_rec_t   mask_due [$];
    mask_rec_t   head;
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          cells_in    = 0;
    int          burst_left  = 0;
    logic        hold_req    = 1'b0;
    logic        hold_done   = 1'b0;
    int          hold_left   = 0;
    rx_style_e   rx_mode     = RX_OPEN;
    int          rx_left     = 0;
    logic [7:0]  rx_pat      = 8'hff;
    logic [2:0]  rx_phase    = '0;

    const cfg_reg_e reg_order [8] = '{REG_A_X, REG_A_Y, REG_B_X, REG_B_Y,
                                      REG_C_X, REG_C_Y, REG_D_X, REG_D_Y};

    // Corner sets a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y; set 0 is the reset state
    const quad_regs_t dir_quads [8] = '{
        '{0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 704, 0, 704, 576, 0, 576},
        '{0, 0, 1023, 0, 1023, 1023, 0, 1023},
        '{11, 0, 100, 0, 100, 100, 11, 100},
        '{0, 0, 11, 0, 11, 100, 0, 100},
        '{300, 300, 300, 300, 300, 300, 300, 300},
        '{100, 50, 600, 50, 350, 500, 350, 500},
        '{0, 16, 100, 16, 100, 100, 0, 100}
    };

    const probe_t probes [N_PROBES] = '{
        // reset corners: empty region everywhere
        '{0, 0, 0, 1, 0}, '{0, 127, 255, 1, 0}, '{0, 89, 159, 1, 0},
        // full source frame: every grid cell in, cells past the grid out
        '{1, 0, 0, 1, 1}, '{1, 89, 159, 1, 1}, '{1, 0, 159, 1, 1}, '{1, 89, 0, 1, 1},
        '{1, 45, 80, 1, 1}, '{1, 90, 0, 1, 0}, '{1, 0, 160, 1, 0}, '{1, 127, 255, 1, 0},
        // corners at the register maximum
        '{2, 127, 255, 0, 0}, '{2, 127, 0, 0, 0}, '{2, 0, 255, 0, 0},
        // center exactly on a left edge, then on a right edge
        '{3, 2, 2, 0, 0}, '{3, 2, 3, 0, 0}, '{3, 2, 1, 0, 0},
        '{4, 2, 2, 0, 0}, '{4, 2, 1, 0, 0},
        // all corners equal, then a triangle with a repeated corner
        '{5, 40, 60, 0, 0},
        '{6, 45, 80, 0, 0}, '{6, 10, 10, 0, 0},
        // horizontal edge through the center row
        '{7, 2, 2, 0, 0}, '{7, 3, 2, 0, 0}, '{7, 2, 40, 0, 0}
    };

    quad_region_grid_mask u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // One edge of the crossing test in the doubled-scale integer space
    function automatic bit edge_flips(longint px, longint py, longint xi, longint yi,
                                      longint xj, longint yj);
        longint lhs;
        longint rhs;
        if ((py < yi) == (py < yj))
            return 1'b0;
        lhs = (px - xi) * (yj - yi);
        rhs = (xj - xi) * (py - yi);
        return (yj > yi) ? (lhs < rhs) : (lhs > rhs);
    endfunction

    // Parity of crossings over edges a-d, b-a, c-b, d-c
    function automatic logic cell_in_quad(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        longint vx [4];
        longint vy [4];
        longint px;
        longint py;
        logic   parity;
        int     j;
        parity = 1'b0;
        for (int k = 0; k < 4; k++) begin
            vx[k] = longint'(quad_now[2 * k]) * VX_SCALE;
            vy[k] = longint'(quad_now[2 * k + 1]) * VY_SCALE;
        end
        px = longint'(SOURCE_WIDTH) * (2 * longint'(col) + 1);
        py = longint'(SOURCE_HEIGHT) * (2 * longint'(row) + 1);
        j = 3;
        for (int k = 0; k < 4; k++) begin
            if (edge_flips(px, py, vx[k], vy[k], vx[j], vy[j]))
                parity = ~parity;
            j = k;
        end
        return parity;
    endfunction

    task automatic log_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Write all eight corner registers back to back, then drop valid
    task automatic load_quad(quad_regs_t q);
        for (int k = 0; k < 8; k++) begin
            cfg_index <= reg_order[k];
            cfg_data  <= q[reg_order[k]];
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
            quad_now[reg_order[k]] = q[reg_order[k]];
        end
        cfg_valid <= 1'b0;
    endtask

    // Stop offering and hold until every pending mask transfer has arrived
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (mask_due.size() != 0)
            @(posedge aclk);
    endtask

    // Offer one cell, record its mask on transfer, then idle if the burst is over
    task automatic offer_cell(int row, int col, bit known, bit want);
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        r = row[ROW_W-1:0];
        c = col[COL_W-1:0];
        s_tdata  <= {1'b0, c, r};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        mask_due.push_back(mask_rec_t'{known ? want : cell_in_quad(r, c), r, c});
        cells_in++;
        if (cells_in == HOLD_AT)
            hold_req <= 1'b1;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // New random corner set, then a run of cells in raster order or scattered
    task automatic run_random_phase(int n);
        quad_regs_t  q;
        quad_style_e style;
        int          x0;
        int          x1;
        int          y0;
        int          y1;
        int          row;
        int          col;
        bit          raster;
        int          xs [3];
        int          ys [3];
        xs = '{0, SOURCE_WIDTH, MAX_CORNER};
        ys = '{0, SOURCE_HEIGHT, MAX_CORNER};
        style = quad_style_e'($urandom_range(0, 3));
        for (int k = 0; k < 4; k++) begin
            case (style)
                QD_SOURCE: begin
                    q[2 * k]     = CORNER_W'($urandom_range(0, SOURCE_WIDTH));
                    q[2 * k + 1] = CORNER_W'($urandom_range(0, SOURCE_HEIGHT));
                end
                QD_FULL: begin
                    q[2 * k]     = CORNER_W'($urandom_range(0, MAX_CORNER));
                    q[2 * k + 1] = CORNER_W'($urandom_range(0, MAX_CORNER));
                end
                default: begin
                    q[2 * k]     = CORNER_W'(xs[$urandom_range(0, 2)]);
                    q[2 * k + 1] = CORNER_W'(ys[$urandom_range(0, 2)]);
                end
            endcase
        end
        // Rectangle whose sides pass exactly through cell centers
        if (style == QD_GRID_RECT) begin
            x0 = 11 * (2 * $urandom_range(0, 15) + 1);
            x1 = 11 * (2 * $urandom_range(16, 31) + 1);
            y0 = 16 * (2 * $urandom_range(0, 8) + 1);
            y1 = 16 * (2 * $urandom_range(9, 17) + 1);
            if ($urandom_range(0, 1))
                q = '{CORNER_W'(x0), CORNER_W'(y0), CORNER_W'(x1), CORNER_W'(y0),
                      CORNER_W'(x1), CORNER_W'(y1), CORNER_W'(x0), CORNER_W'(y1)};
            else
                q = '{CORNER_W'(x0), CORNER_W'(y0), CORNER_W'(x0), CORNER_W'(y1),
                      CORNER_W'(x1), CORNER_W'(y1), CORNER_W'(x1), CORNER_W'(y0)};
        end
        settle_idle();
        load_quad(q);
        raster = $urandom_range(0, 1);
        row = $urandom_range(0, GRID_ROWS - 1);
        col = $urandom_range(0, GRID_COLS - 1);
        for (int i = 0; i < n; i++) begin
            if (raster) begin
                offer_cell(row, col, 1'b0, 1'b0);
                col = (col + 1) % GRID_COLS;
                if (col == 0)
                    row = (row + 1) % GRID_ROWS;
            end else if ($urandom_range(0, 7) == 0) begin
                offer_cell($urandom_range(0, MAX_ROW), $urandom_range(0, MAX_COL), 1'b0, 1'b0);
            end else begin
                offer_cell($urandom_range(0, GRID_ROWS - 1), $urandom_range(0, GRID_COLS - 1),
                           1'b0, 1'b0);
            end
        end
    endtask

    // Main sequence: reset, directed table, random phases, drain and verdict
    initial begin
        int ph;
        int random_cells;
        ph = 0;
        random_cells = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < N_PROBES; i++) begin
            if (probes[i].ph != ph) begin
                ph = probes[i].ph;
                settle_idle();
                load_quad(dir_quads[ph]);
            end
            offer_cell(probes[i].row, probes[i].col, probes[i].known, probes[i].want);
        end
        while (random_cells < RANDOM_CELLS) begin
            int n;
            n = $urandom_range(40, 160);
            run_random_phase(n);
            random_cells += n;
        end
        settle_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: one long hold-off once traffic is up, otherwise changing stall styles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= rx_style_e'($urandom_range(0, 3));
                rx_left <= $urandom_range(20, 200);
                rx_pat  <= 8'($urandom_range(1, 255));
            end else begin
                rx_left <= rx_left - 1;
            end
            rx_phase <= rx_phase + 1'b1;
            case (rx_mode)
                RX_OPEN:    m_tready <= 1'b1;
                RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
                RX_PATTERN: m_tready <= rx_pat[rx_phase];
                default:    m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Compare each mask transfer with the oldest pending prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (mask_due.size() == 0) begin
                log_mismatch($sformatf("unexpected transfer tdata=%h", m_tdata));
            end else begin
                head = mask_due.pop_front();
                if (m_tdata[0] !== head.in_quad)
                    log_mismatch($sformatf("inside got %b want %b (row %0d col %0d)",
                                           m_tdata[0], head.in_quad, head.row, head.col));
                if (m_tdata[7:1] !== head.row)
                    log_mismatch($sformatf("row got %0d want %0d", m_tdata[7:1], head.row));
                if (m_tdata[15:8] !== head.col)
                    log_mismatch($sformatf("col got %0d want %0d", m_tdata[15:8], head.col));
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

// File: filelist.f
hw/rtl/qrgm_pkg.sv
hw/rtl/qrgm_cfg.sv
hw/rtl/qrgm_edge.sv
hw/rtl/quad_region_grid_mask.sv
verif/quad_region_grid_mask_tb.sv
